// ----- sv/bmpd_pkg.sv -----
`default_nettype none

package bmpd_pkg;

    localparam int MAX_SIDE        = 8192;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int SIDE_W          = $clog2(MAX_SIDE) + 1;
    localparam int COORD_W         = $clog2(MAX_SIDE);
    localparam int OUTQ_DEPTH      = 4;
    localparam int OUTQ_AW         = $clog2(OUTQ_DEPTH);

    // header byte positions
    localparam logic [31:0] POS_MAGIC0  = 32'd0;
    localparam logic [31:0] POS_MAGIC1  = 32'd1;
    localparam logic [31:0] POS_OFFSET  = 32'd13;
    localparam logic [31:0] POS_HSIZE   = 32'd17;
    localparam logic [31:0] POS_WIDTH   = 32'd21;
    localparam logic [31:0] POS_HEIGHT  = 32'd25;
    localparam logic [31:0] POS_DEPTH   = 32'd29;
    localparam logic [31:0] POS_COMP    = 32'd33;
    localparam logic [31:0] POS_COLORS  = 32'd49;
    localparam logic [31:0] INFO_END    = 32'd54;
    localparam logic [31:0] FILE_HDR    = 32'd14;
    localparam logic [31:0] MIN_HSIZE   = 32'd40;

    localparam logic [7:0] MAGIC_B = 8'h42;
    localparam logic [7:0] MAGIC_M = 8'h4D;

    localparam logic [5:0] DEPTH_8  = 6'd8;
    localparam logic [5:0] DEPTH_24 = 6'd24;
    localparam logic [5:0] DEPTH_32 = 6'd32;

    // fault mask bits
    localparam int F_MAGIC = 0;
    localparam int F_DIMS  = 1;
    localparam int F_COMP  = 2;
    localparam int F_DEPTH = 3;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_SHORT   = 4'd1;
    localparam logic [3:0] ST_MAGIC   = 4'd2;
    localparam logic [3:0] ST_HSIZE   = 4'd3;
    localparam logic [3:0] ST_DIMS    = 4'd4;
    localparam logic [3:0] ST_COMP    = 4'd5;
    localparam logic [3:0] ST_DEPTH   = 4'd6;
    localparam logic [3:0] ST_PALCUT  = 4'd7;
    localparam logic [3:0] ST_PIXCUT  = 4'd8;
    localparam logic [3:0] ST_OFFSET  = 4'd9;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [3:0]         status;
        logic [SIDE_W-1:0]  image_width;
        logic [SIDE_W-1:0]  image_height;
        logic               last;
    } out_word_t;

    // work handed from the parser stage to result assembly
    typedef struct packed {
        logic               pix_valid;
        logic               pal_mode;
        logic               idx_ok;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               sts_valid;
        logic [3:0]         status;
        logic [SIDE_W-1:0]  width;
        logic [SIDE_W-1:0]  height;
    } stage_t;

endpackage

`default_nettype wire

// ----- sv/bmp_stream_decoder_core.sv -----
// channel   signals                            word
// --------  ---------------------------------  ---------------------------
// file      file_valid, file_stall, file_data  one file byte + end flag
// result    res_valid, res_stall, res_data     one pixel or final status
//
// One file byte a cycle unless file_stall is high; the parser stage registers
// each byte's result before queueing. Parser and palette port set the rate.
// A byte that ends the file may give a pixel and a status: two result words.
// file_stall rises when the four-word result queue could not absorb both.
// rst_n clears all control state; palette contents stay unknown until loaded.
`default_nettype none

module bmp_stream_decoder_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            file_valid,
    output logic                 file_stall,
    input  bmpd_pkg::in_word_t   file_data,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output bmpd_pkg::out_word_t  res_data
);

    logic                accept;
    logic                pal_we;
    logic [bmpd_pkg::PAL_AW-1:0] pal_waddr, pal_raddr;
    logic [23:0]         pal_wdata, pal_rdata;
    bmpd_pkg::stage_t    stage;
    bmpd_pkg::out_word_t pix_word, sts_word;
    logic [bmpd_pkg::OUTQ_AW:0] fill;
    logic [3:0]          need;

    assign accept = file_valid && !file_stall;

    // hold input while queue plus words in flight could overflow
    assign need       = {1'b0, fill} + 4'(stage.pix_valid) + 4'(stage.sts_valid) + 4'd2;
    assign file_stall = need > 4'(bmpd_pkg::OUTQ_DEPTH);

    bmpd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word      (file_data),
        .pal_we    (pal_we),
        .pal_waddr (pal_waddr),
        .pal_wdata (pal_wdata),
        .pal_raddr (pal_raddr),
        .stage     (stage)
    );

    bmpd_ram #(
        .WIDTH (24),
        .DEPTH (bmpd_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    always_comb
    begin
        pix_word             = '0;
        pix_word.result_kind = bmpd_pkg::KIND_PIXEL;
        pix_word.column      = stage.column;
        pix_word.row         = stage.row;
        if (stage.pal_mode)
        begin
            // index past the palette reads as black
            if (stage.idx_ok)
            begin
                pix_word.red   = pal_rdata[23:16];
                pix_word.green = pal_rdata[15:8];
                pix_word.blue  = pal_rdata[7:0];
            end
        end
        else
        begin
            pix_word.red   = stage.red;
            pix_word.green = stage.green;
            pix_word.blue  = stage.blue;
        end

        sts_word              = '0;
        sts_word.result_kind  = bmpd_pkg::KIND_STATUS;
        sts_word.status       = stage.status;
        sts_word.image_width  = stage.width;
        sts_word.image_height = stage.height;
        sts_word.last         = 1'b1;
    end

    bmpd_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_a_valid (stage.pix_valid || stage.sts_valid),
        .wr_a       (stage.pix_valid ? pix_word : sts_word),
        .wr_b_valid (stage.pix_valid && stage.sts_valid),
        .wr_b       (sts_word),
        .rd_valid   (res_valid),
        .rd_word    (res_data),
        .rd_stall   (res_stall),
        .fill       (fill)
    );

`ifndef ASSERT_OFF
    a_sts_from_eof: assert property (@(posedge clk) disable iff (!rst_n)
        stage.sts_valid |-> $past(accept && file_data.end_of_file))
        else $error("status word without end of file");

    a_pix_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        stage.pix_valid |-> $past(accept))
        else $error("pixel word without accepted byte");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= (bmpd_pkg::OUTQ_AW + 1)'(bmpd_pkg::OUTQ_DEPTH))
        else $error("result queue overflow");

    a_res_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(res_valid) |-> $past(!res_stall))
        else $error("result word lost while stalled");
`endif

endmodule

`default_nettype wire

// ----- sv/bmpd_ram.sv -----
`default_nettype none

module bmpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/bmpd_parse.sv -----
`default_nettype none

module bmpd_parse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  bmpd_pkg::in_word_t     word,
    output logic                   pal_we,
    output logic [bmpd_pkg::PAL_AW-1:0] pal_waddr,
    output logic [23:0]            pal_wdata,
    output logic [bmpd_pkg::PAL_AW-1:0] pal_raddr,
    output bmpd_pkg::stage_t       stage
);

    localparam int SW = bmpd_pkg::SIDE_W;
    localparam int CW = bmpd_pkg::COORD_W;

    logic [31:0]   pos_reg, pos_next;
    logic          ovf_reg, ovf_next;
    logic [31:0]   shift_reg, shift_next;
    logic [31:0]   pstart_reg, pstart_next;
    logic [31:0]   hsize_reg, hsize_next;
    logic [SW-1:0] width_reg, width_next;
    logic [SW-1:0] height_reg, height_next;
    logic          bottom_up_reg, bottom_up_next;
    logic [5:0]    depth_reg, depth_next;
    logic [8:0]    pal_used_reg, pal_used_next;
    logic [15:0]   partial_reg, partial_next;
    logic [14:0]   bir_reg, bir_next;
    logic [CW-1:0] col_reg, col_next;
    logic [SW-1:0] rowc_reg, rowc_next;
    logic [3:0]    faults_reg, faults_next;
    logic [1:0]    lane_reg, lane_next;
    bmpd_pkg::stage_t stage_reg, stage_next;

    // figures derived from the header, refreshed every cycle
    logic [15:0] stride_reg, rowbytes_reg;
    logic [29:0] span_reg;
    logic [32:0] pend_reg;
    logic [32:0] hend_reg;
    logic [33:0] floor_reg;
    logic        start_ok_reg, hs_ok_reg;

    logic [18:0] bits_w;
    logic [16:0] rowbytes_w;
    logic [7:0]  b;
    logic [31:0] sh;
    logic [31:0] mag;
    logic [15:0] bc;
    logic        pal_win, pix_go;
    logic [9:0]  k;
    logic [2:0]  bpp;
    logic [SW-1:0] row_w;
    logic [15:0] bir_inc;
    logic [32:0] size;
    logic [3:0]  st;

    assign pal_raddr = word.file_byte;
    assign stage     = stage_reg;

    always_comb
    begin
        unique case (depth_reg)
            bmpd_pkg::DEPTH_8:  bits_w = {2'b0, width_reg, 3'b0};
            bmpd_pkg::DEPTH_24: bits_w = {1'b0, width_reg, 4'b0} + {2'b0, width_reg, 3'b0};
            bmpd_pkg::DEPTH_32: bits_w = {width_reg, 5'b0};
            default:            bits_w = '0;
        endcase
        rowbytes_w = {3'b0, width_reg} * {14'b0, depth_reg[5:3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg   <= '0;
            rowbytes_reg <= '0;
            span_reg     <= '0;
            pend_reg     <= '0;
            hend_reg     <= '0;
            floor_reg    <= '0;
            start_ok_reg <= 1'b0;
            hs_ok_reg    <= 1'b0;
        end
        else
        begin
            stride_reg   <= 16'((({1'b0, bits_w} + 20'd31) >> 5) << 2);
            rowbytes_reg <= rowbytes_w[15:0];
            span_reg     <= {14'b0, stride_reg} * {16'b0, height_reg};
            pend_reg     <= {1'b0, pstart_reg} + {3'b0, span_reg};
            hend_reg     <= {1'b0, hsize_reg} + {1'b0, bmpd_pkg::FILE_HDR};
            floor_reg    <= {1'b0, hend_reg}
                          + ((depth_reg == bmpd_pkg::DEPTH_8) ? {23'b0, pal_used_reg, 2'b0}
                                                              : 34'd0);
            start_ok_reg <= {2'b0, pstart_reg} >= floor_reg;
            hs_ok_reg    <= hsize_reg >= bmpd_pkg::MIN_HSIZE;
        end
    end

    always_comb
    begin
        b   = word.file_byte;
        sh  = {b, shift_reg[31:8]};
        mag = sh[31] ? (32'd0 - sh) : sh;
        bc  = sh[31:16];
        bpp = depth_reg[5:3];
        k   = pos_reg[9:0] - hend_reg[9:0];
        row_w   = bottom_up_reg ? (height_reg - SW'(1) - rowc_reg) : rowc_reg;
        bir_inc = {1'b0, bir_reg} + 16'd1;

        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        shift_next     = shift_reg;
        pstart_next    = pstart_reg;
        hsize_next     = hsize_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        bottom_up_next = bottom_up_reg;
        depth_next     = depth_reg;
        pal_used_next  = pal_used_reg;
        partial_next   = partial_reg;
        bir_next       = bir_reg;
        col_next       = col_reg;
        rowc_next      = rowc_reg;
        faults_next    = faults_reg;
        lane_next      = lane_reg;

        pal_we    = 1'b0;
        pal_waddr = k[9:2];
        pal_wdata = {b, partial_reg};

        stage_next        = '0;
        stage_next.column = col_reg;
        stage_next.row    = row_w[CW-1:0];

        pal_win = (pos_reg >= bmpd_pkg::INFO_END) && (depth_reg == bmpd_pkg::DEPTH_8)
               && ({1'b0, pos_reg} >= hend_reg) && ({2'b0, pos_reg} < floor_reg);
        pix_go  = (pos_reg >= bmpd_pkg::INFO_END) && (faults_reg == '0) && hs_ok_reg
               && (depth_reg != '0) && (pos_reg >= pstart_reg) && start_ok_reg
               && (rowc_reg < height_reg);

        size = ovf_reg ? 33'h1_0000_0000 : ({1'b0, pos_reg} + 33'd1);
        if (size < {1'b0, bmpd_pkg::INFO_END})
            st = bmpd_pkg::ST_SHORT;
        else if (faults_reg[bmpd_pkg::F_MAGIC])
            st = bmpd_pkg::ST_MAGIC;
        else if (!hs_ok_reg || (hend_reg > size))
            st = bmpd_pkg::ST_HSIZE;
        else if (faults_reg[bmpd_pkg::F_DIMS])
            st = bmpd_pkg::ST_DIMS;
        else if (faults_reg[bmpd_pkg::F_COMP])
            st = bmpd_pkg::ST_COMP;
        else if (faults_reg[bmpd_pkg::F_DEPTH])
            st = bmpd_pkg::ST_DEPTH;
        else if ((depth_reg == bmpd_pkg::DEPTH_8) && (floor_reg > {1'b0, size}))
            st = bmpd_pkg::ST_PALCUT;
        else if (!start_ok_reg)
            st = bmpd_pkg::ST_OFFSET;
        else if (({1'b0, pstart_reg} >= size) || (pend_reg > size))
            st = bmpd_pkg::ST_PIXCUT;
        else
            st = bmpd_pkg::ST_OK;

        if (accept && !ovf_reg)
        begin
            shift_next = sh;
            unique case (pos_reg)
                bmpd_pkg::POS_MAGIC0:
                    if (b != bmpd_pkg::MAGIC_B) faults_next[bmpd_pkg::F_MAGIC] = 1'b1;
                bmpd_pkg::POS_MAGIC1:
                    if (b != bmpd_pkg::MAGIC_M) faults_next[bmpd_pkg::F_MAGIC] = 1'b1;
                bmpd_pkg::POS_OFFSET: pstart_next = sh;
                bmpd_pkg::POS_HSIZE:  hsize_next = sh;
                bmpd_pkg::POS_WIDTH:
                    if (sh >= 32'd1 && sh <= 32'(bmpd_pkg::MAX_SIDE)) width_next = sh[SW-1:0];
                    else faults_next[bmpd_pkg::F_DIMS] = 1'b1;
                bmpd_pkg::POS_HEIGHT:
                begin
                    bottom_up_next = !sh[31] && (sh != '0);
                    if (mag >= 32'd1 && mag <= 32'(bmpd_pkg::MAX_SIDE))
                        height_next = mag[SW-1:0];
                    else
                        faults_next[bmpd_pkg::F_DIMS] = 1'b1;
                end
                bmpd_pkg::POS_DEPTH:
                    if (bc == 16'd8 || bc == 16'd24 || bc == 16'd32) depth_next = bc[5:0];
                    else faults_next[bmpd_pkg::F_DEPTH] = 1'b1;
                bmpd_pkg::POS_COMP:
                    if (sh != '0) faults_next[bmpd_pkg::F_COMP] = 1'b1;
                bmpd_pkg::POS_COLORS:
                    pal_used_next = (sh == '0 || sh > 32'(bmpd_pkg::PALETTE_ENTRIES))
                                  ? 9'(bmpd_pkg::PALETTE_ENTRIES) : sh[8:0];
                default: ;
            endcase

            // palette entries arrive as B, G, R, A
            if (pal_win)
            begin
                case (k[1:0])
                    2'd0: partial_next = {8'b0, b};
                    2'd1: partial_next = {b, partial_reg[7:0]};
                    2'd2: pal_we = 1'b1;
                    default: ;
                endcase
            end

            if (pix_go)
            begin
                if ({1'b0, bir_reg} < rowbytes_reg)
                begin
                    if (depth_reg == bmpd_pkg::DEPTH_8)
                    begin
                        stage_next.pix_valid = 1'b1;
                        stage_next.pal_mode  = 1'b1;
                        stage_next.idx_ok    = {1'b0, b} < pal_used_reg;
                        col_next             = col_reg + CW'(1);
                    end
                    else
                    begin
                        case (lane_reg)
                            2'd0: partial_next = {8'b0, b};
                            2'd1: partial_next = {b, partial_reg[7:0]};
                            2'd2:
                            begin
                                stage_next.pix_valid = 1'b1;
                                stage_next.red       = b;
                                stage_next.green     = partial_reg[15:8];
                                stage_next.blue      = partial_reg[7:0];
                            end
                            default: ;
                        endcase
                        if ({1'b0, lane_reg} + 3'd1 >= bpp)
                        begin
                            lane_next = '0;
                            col_next  = col_reg + CW'(1);
                        end
                        else
                        begin
                            lane_next = lane_reg + 2'd1;
                        end
                    end
                end
                // drop row padding, advance to the next row at the stride
                if (bir_inc >= stride_reg)
                begin
                    bir_next  = '0;
                    col_next  = '0;
                    lane_next = '0;
                    rowc_next = rowc_reg + SW'(1);
                end
                else
                begin
                    bir_next = bir_inc[14:0];
                end
            end

            if (pos_reg == 32'hFFFF_FFFF) ovf_next = 1'b1;
            else pos_next = pos_reg + 32'd1;
        end

        if (accept && word.end_of_file)
        begin
            stage_next.sts_valid = 1'b1;
            stage_next.status    = st;
            stage_next.width     = (st == bmpd_pkg::ST_OK) ? width_reg : '0;
            stage_next.height    = (st == bmpd_pkg::ST_OK) ? height_reg : '0;
            pos_next       = '0;
            ovf_next       = 1'b0;
            shift_next     = '0;
            pstart_next    = '0;
            hsize_next     = '0;
            width_next     = '0;
            height_next    = '0;
            bottom_up_next = 1'b0;
            depth_next     = '0;
            pal_used_next  = '0;
            partial_next   = '0;
            bir_next       = '0;
            col_next       = '0;
            rowc_next      = '0;
            faults_next    = '0;
            lane_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            shift_reg     <= '0;
            pstart_reg    <= '0;
            hsize_reg     <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            bottom_up_reg <= 1'b0;
            depth_reg     <= '0;
            pal_used_reg  <= '0;
            partial_reg   <= '0;
            bir_reg       <= '0;
            col_reg       <= '0;
            rowc_reg      <= '0;
            faults_reg    <= '0;
            lane_reg      <= '0;
            stage_reg     <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            shift_reg     <= shift_next;
            pstart_reg    <= pstart_next;
            hsize_reg     <= hsize_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            bottom_up_reg <= bottom_up_next;
            depth_reg     <= depth_next;
            pal_used_reg  <= pal_used_next;
            partial_reg   <= partial_next;
            bir_reg       <= bir_next;
            col_reg       <= col_next;
            rowc_reg      <= rowc_next;
            faults_reg    <= faults_next;
            lane_reg      <= lane_next;
            stage_reg     <= stage_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bmpd_outq.sv -----
`default_nettype none

module bmpd_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_a_valid,
    input  bmpd_pkg::out_word_t      wr_a,
    input  wire logic                wr_b_valid,
    input  bmpd_pkg::out_word_t      wr_b,
    output logic                     rd_valid,
    output bmpd_pkg::out_word_t      rd_word,
    input  wire logic                rd_stall,
    output logic [bmpd_pkg::OUTQ_AW:0] fill
);

    localparam int AW = bmpd_pkg::OUTQ_AW;

    bmpd_pkg::out_word_t ent_reg [bmpd_pkg::OUTQ_DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW:0]   count_reg, count_next;
    logic [AW-1:0] tail_a, tail_b;
    logic          pop;

    assign rd_valid = count_reg != '0;
    assign rd_word  = ent_reg[head_reg];
    assign fill     = count_reg;
    assign pop      = rd_valid && !rd_stall;
    assign tail_a   = head_reg + count_reg[AW-1:0];
    assign tail_b   = tail_a + AW'(wr_a_valid);

    always_comb
    begin
        head_next  = head_reg + AW'(pop);
        count_next = count_reg + (AW+1)'(wr_a_valid) + (AW+1)'(wr_b_valid) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr_a_valid)
        begin
            ent_reg[tail_a] <= wr_a;
        end
        if (wr_b_valid)
        begin
            ent_reg[tail_b] <= wr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    typedef logic [7:0] byte_q_t[$];

    // Mirrors the decoder byte by byte and holds the result words still owed.
    class bmp_scoreboard;
        bmpd_pkg::out_word_t owed[$];
        int         mismatches;
        int         pixels_seen;
        int         statuses_seen;
        int         status_hits[16];

        logic [31:0] pos;
        bit          pos_sat;
        logic [31:0] shift;
        longint      pix_start;
        longint      hdr_size;
        int          width;
        int          height;
        bit          bottom_up;
        int          depth;
        int          pal_used;
        logic [23:0] palette[bmpd_pkg::PALETTE_ENTRIES];
        logic [15:0] partial;
        int          byte_in_row;
        logic [12:0] col;
        int          row_count;
        logic [3:0]  faults;
        int          lane;

        function new();
            mismatches = 0;
            pixels_seen = 0;
            statuses_seen = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
            restart();
        endfunction

        function void restart();
            pos = '0;
            pos_sat = 0;
            shift = '0;
            pix_start = 0;
            hdr_size = 0;
            width = 0;
            height = 0;
            bottom_up = 0;
            depth = 0;
            pal_used = 0;
            partial = '0;
            byte_in_row = 0;
            col = '0;
            row_count = 0;
            faults = '0;
            lane = 0;
        endfunction

        function bmpd_pkg::out_word_t make_word(logic kind, logic [7:0] r, logic [7:0] g,
                                                logic [7:0] b, logic [12:0] c,
                                                logic [12:0] rw, logic [3:0] st,
                                                logic [13:0] w, logic [13:0] h);
            bmpd_pkg::out_word_t o;
            o.result_kind = kind;
            o.red = r;
            o.green = g;
            o.blue = b;
            o.column = c;
            o.row = rw;
            o.status = st;
            o.image_width = w;
            o.image_height = h;
            o.last = kind;
            return o;
        endfunction

        function longint data_floor();
            longint f;
            f = 14 + hdr_size;
            if (depth == 8)
                f += longint'(pal_used) * 4;
            return f;
        endfunction

        function longint row_stride();
            return ((longint'(width) * depth + 31) >> 5) << 2;
        endfunction

        function logic [3:0] file_status(longint size);
            if (size < 54)
                return bmpd_pkg::ST_SHORT;
            if (faults[bmpd_pkg::F_MAGIC])
                return bmpd_pkg::ST_MAGIC;
            if (hdr_size < 40 || 14 + hdr_size > size)
                return bmpd_pkg::ST_HSIZE;
            if (faults[bmpd_pkg::F_DIMS])
                return bmpd_pkg::ST_DIMS;
            if (faults[bmpd_pkg::F_COMP])
                return bmpd_pkg::ST_COMP;
            if (faults[bmpd_pkg::F_DEPTH])
                return bmpd_pkg::ST_DEPTH;
            if (depth == 8 && data_floor() > size)
                return bmpd_pkg::ST_PALCUT;
            if (pix_start < data_floor())
                return bmpd_pkg::ST_OFFSET;
            if (pix_start >= size || pix_start + row_stride() * height > size)
                return bmpd_pkg::ST_PIXCUT;
            return bmpd_pkg::ST_OK;
        endfunction

        function void note_byte(bmpd_pkg::in_word_t w);
            logic [31:0] b;
            logic [31:0] p;
            logic [31:0] mag;
            longint      pl;
            longint      k;
            int          bpp;
            int          rw;
            logic [23:0] e;
            logic [3:0]  st;
            longint      size;
            b = {24'd0, w.file_byte};
            p = pos;
            pl = longint'(p);
            if (!pos_sat)
            begin
                shift = (shift >> 8) | (b << 24);
                case (p)
                    bmpd_pkg::POS_MAGIC0:
                        if (w.file_byte != bmpd_pkg::MAGIC_B) faults[bmpd_pkg::F_MAGIC] = 1'b1;
                    bmpd_pkg::POS_MAGIC1:
                        if (w.file_byte != bmpd_pkg::MAGIC_M) faults[bmpd_pkg::F_MAGIC] = 1'b1;
                    bmpd_pkg::POS_OFFSET: pix_start = longint'(shift);
                    bmpd_pkg::POS_HSIZE:  hdr_size = longint'(shift);
                    bmpd_pkg::POS_WIDTH:
                        if (shift >= 1 && shift <= bmpd_pkg::MAX_SIDE)
                            width = int'(shift);
                        else
                            faults[bmpd_pkg::F_DIMS] = 1'b1;
                    bmpd_pkg::POS_HEIGHT:
                    begin
                        if (shift[31])
                        begin
                            mag = -shift;
                            bottom_up = 0;
                        end
                        else
                        begin
                            mag = shift;
                            bottom_up = (shift != 0);
                        end
                        if (mag >= 1 && mag <= bmpd_pkg::MAX_SIDE)
                            height = int'(mag);
                        else
                            faults[bmpd_pkg::F_DIMS] = 1'b1;
                    end
                    bmpd_pkg::POS_DEPTH:
                        if (shift[31:16] == 8 || shift[31:16] == 24 || shift[31:16] == 32)
                            depth = int'(shift[31:16]);
                        else
                            faults[bmpd_pkg::F_DEPTH] = 1'b1;
                    bmpd_pkg::POS_COMP:
                        if (shift != 0) faults[bmpd_pkg::F_COMP] = 1'b1;
                    bmpd_pkg::POS_COLORS:
                        pal_used = (shift == 0 || shift > bmpd_pkg::PALETTE_ENTRIES) ?
                                   bmpd_pkg::PALETTE_ENTRIES : int'(shift);
                    default: ;
                endcase

                // palette entries arrive as B, G, R, then an ignored alpha byte
                if (pl >= 54 && depth == 8)
                begin
                    k = pl - (14 + hdr_size);
                    if (k >= 0 && k < longint'(pal_used) * 4)
                    begin
                        case (k & 3)
                            0: partial = {8'd0, w.file_byte};
                            1: partial[15:8] = w.file_byte;
                            2: palette[(k >> 2) & 255] = {w.file_byte, partial};
                            default: ;
                        endcase
                    end
                end

                if (pl >= 54 && faults == 0 && hdr_size >= 40 && depth != 0 &&
                    pl >= pix_start && pix_start >= data_floor() && row_count < height)
                begin
                    bpp = depth / 8;
                    rw = bottom_up ? height - 1 - row_count : row_count;
                    if (byte_in_row < width * bpp)
                    begin
                        if (depth == 8)
                        begin
                            e = (b < pal_used) ? palette[w.file_byte] : 24'd0;
                            owed.push_back(make_word(bmpd_pkg::KIND_PIXEL, e[23:16], e[15:8],
                                                     e[7:0], col, rw[12:0], bmpd_pkg::ST_OK,
                                                     14'd0, 14'd0));
                            col = col + 13'd1;
                        end
                        else
                        begin
                            if (lane == 0)
                                partial = {8'd0, w.file_byte};
                            else if (lane == 1)
                                partial[15:8] = w.file_byte;
                            else if (lane == 2)
                                owed.push_back(make_word(bmpd_pkg::KIND_PIXEL, w.file_byte,
                                                         partial[15:8], partial[7:0],
                                                         col, rw[12:0], bmpd_pkg::ST_OK,
                                                         14'd0, 14'd0));
                            if (lane + 1 >= bpp)
                            begin
                                lane = 0;
                                col = col + 13'd1;
                            end
                            else
                                lane++;
                        end
                    end
                    byte_in_row++;
                    if (byte_in_row >= row_stride())
                    begin
                        byte_in_row = 0;
                        col = '0;
                        lane = 0;
                        row_count++;
                    end
                end

                if (p == 32'hFFFF_FFFF)
                    pos_sat = 1;
                else
                    pos = p + 32'd1;
            end

            if (w.end_of_file)
            begin
                size = pos_sat ? 64'h1_0000_0000 : pl + 1;
                st = file_status(size);
                owed.push_back(make_word(bmpd_pkg::KIND_STATUS, 8'd0, 8'd0, 8'd0, 13'd0, 13'd0,
                                         st, (st == bmpd_pkg::ST_OK) ? 14'(width) : 14'd0,
                                         (st == bmpd_pkg::ST_OK) ? 14'(height) : 14'd0));
                restart();
            end
        endfunction

        function void check_result(bmpd_pkg::out_word_t got);
            bmpd_pkg::out_word_t e;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %h", got);
                return;
            end
            e = owed.pop_front();
            if (got.result_kind == bmpd_pkg::KIND_STATUS)
            begin
                statuses_seen++;
                status_hits[e.status]++;
            end
            else
                pixels_seen++;
            if (got.result_kind !== e.result_kind || got.red !== e.red ||
                got.green !== e.green || got.blue !== e.blue ||
                got.column !== e.column || got.row !== e.row ||
                got.status !== e.status || got.image_width !== e.image_width ||
                got.image_height !== e.image_height || got.last !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: kind %0d/%0d rgb %h%h%h/%h%h%h col %0d/%0d row %0d/%0d %s",
                             e.result_kind, got.result_kind, e.red, e.green, e.blue,
                             got.red, got.green, got.blue, e.column, got.column,
                             e.row, got.row, $sformatf("st %0d/%0d w %0d/%0d h %0d/%0d last %b/%b",
                             e.status, got.status, e.image_width, got.image_width,
                             e.image_height, got.image_height, e.last, got.last));
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                file_valid;
    logic                file_stall;
    bmpd_pkg::in_word_t  file_data;
    logic                res_valid;
    logic                res_stall;
    bmpd_pkg::out_word_t res_data;

    bmp_scoreboard sb;
    bit  calm;
    bit  hold_req;
    int  res_gap;
    int  idle_cycles;
    int  bytes_sent;
    int  files_sent;

    bmp_stream_decoder_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .file_valid (file_valid),
        .file_stall (file_stall),
        .file_data  (file_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    always #1 clk = ~clk;

    function automatic void put32(ref byte_q_t f, input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            f.push_back(v[8*i +: 8]);
    endfunction

    // Build a BMP file; gap < 0 points the pixel offset back into the headers or palette,
    // keep > 0 cuts the file to at most that many bytes.
    function automatic void make_bmp(ref byte_q_t f, input int dep, input int w, input int h,
                                     input int ncol, input int hsz, input int comp,
                                     input int gap, input int tail, input int keep);
        int npal;
        int stride;
        int rows;
        int total;
        f.delete();
        npal = (ncol == 0 || ncol > bmpd_pkg::PALETTE_ENTRIES) ? bmpd_pkg::PALETTE_ENTRIES
                                                               : ncol;
        stride = ((w * dep + 31) / 32) * 4;
        rows = (h < 0) ? -h : h;
        f.push_back(bmpd_pkg::MAGIC_B);
        f.push_back(bmpd_pkg::MAGIC_M);
        put32(f, 32'd0);
        put32(f, $urandom);
        put32(f, 32'(14 + hsz + ((dep == 8) ? 4 * npal : 0) + gap));
        put32(f, 32'(hsz));
        put32(f, 32'(w));
        put32(f, 32'(h));
        f.push_back(8'd1);
        f.push_back(8'd0);
        f.push_back(dep[7:0]);
        f.push_back(dep[15:8]);
        put32(f, 32'(comp));
        put32(f, $urandom);
        put32(f, $urandom);
        put32(f, $urandom);
        put32(f, 32'(ncol));
        put32(f, $urandom);
        for (int i = 40; i < hsz; i++)
            f.push_back(8'($urandom));
        if (dep == 8)
            for (int i = 0; i < 4 * npal && (keep == 0 || f.size() < keep); i++)
                f.push_back(8'($urandom));
        for (int i = 0; i < gap; i++)
            f.push_back(8'($urandom));
        total = stride * rows;
        for (int i = 0; i < total && (keep == 0 || f.size() < keep); i++)
            if (dep == 8 && $urandom_range(0, 1))
                f.push_back(8'($urandom_range(0, npal)));
            else
                f.push_back(8'($urandom));
        for (int i = 0; i < tail; i++)
            f.push_back(8'($urandom));
        while (keep > 0 && f.size() > keep)
            void'(f.pop_back());
        if (f.size() >= 4)
        begin
            f[2] = 8'(f.size());
            f[3] = 8'(f.size() >> 8);
        end
    endfunction

    // Starts and ends at a falling edge; valid stays high across back-to-back words.
    task automatic send_file(input byte_q_t f);
        int gap;
        for (int i = 0; i < f.size(); i++)
        begin
            gap = calm ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                file_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            file_valid <= 1'b1;
            file_data <= {f[i], i == f.size() - 1};
            do
                @(posedge clk);
            while (file_stall);
            sb.note_byte(file_data);
            bytes_sent++;
            @(negedge clk);
        end
        files_sent++;
    endtask

    // result side: random stall per word, plus one long hold-off on request
    initial
    begin
        res_stall = 1'b0;
        res_gap = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                res_stall <= 1'b1;
                repeat (120) @(negedge clk);
            end
            if (res_gap > 0)
            begin
                res_stall <= 1'b1;
                res_gap--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            sb.check_result(res_data);
            res_gap = calm ? 0 : $urandom_range(0, 9);
        end
    end

    always @(posedge clk)
    begin
        if ((file_valid && !file_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000)
        begin
            $display("ERROR: no handshake for %0d cycles", idle_cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        byte_q_t f;
        int sel;
        int dep;
        int w;
        int h;
        int gap;
        clk = 1'b0;
        rst_n = 1'b0;
        file_valid = 1'b0;
        file_data = '0;
        calm = 0;
        hold_req = 0;
        idle_cycles = 0;
        bytes_sent = 0;
        files_sent = 0;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // the result side holds off once while the first file streams in
        hold_req = 1;

        // directed files: good images, then each failure cause
        make_bmp(f, 24, 3, 2, 0, 40, 0, 0, 0, 0);      send_file(f);
        make_bmp(f, 8, 5, 2, 4, 40, 0, 0, 0, 0);       send_file(f);
        make_bmp(f, 8, 4, 1, 0, 40, 0, 0, 0, 60);      send_file(f);
        make_bmp(f, 24, 2, 1, 0, 40, 0, 0, 0, 10);     send_file(f);
        make_bmp(f, 24, 2, 1, 0, 40, 0, 0, 0, 0);
        f[1] = 8'h00;                                  send_file(f);
        make_bmp(f, 24, 2, 1, 0, 30, 0, 0, 0, 0);      send_file(f);
        make_bmp(f, 24, 8193, 1, 0, 40, 0, 0, 0, 60);  send_file(f);
        make_bmp(f, 32, 8192, 1, 0, 40, 0, 0, 0, 60);  send_file(f);
        make_bmp(f, 24, 2, 1, 0, 40, 1, 0, 0, 0);      send_file(f);
        make_bmp(f, 16, 2, 1, 0, 40, 0, 0, 0, 0);      send_file(f);
        make_bmp(f, 8, 2, 1, 3, 40, 0, -2, 0, 0);      send_file(f);

        // random files, mostly well formed
        while (bytes_sent < 750)
        begin
            calm = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 9);
            case ($urandom_range(0, 2))
                0: dep = 8;
                1: dep = 24;
                default: dep = 32;
            endcase
            w = $urandom_range(1, 5);
            h = $urandom_range(1, 3);
            if ($urandom_range(0, 1))
                h = -h;
            gap = (sel == 3) ? -$urandom_range(1, 4) :
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            make_bmp(f, dep, w, h,
                     ($urandom_range(0, 39) == 0) ? 0 : $urandom_range(1, 12),
                     ($urandom_range(0, 3) == 0) ? 40 + $urandom_range(1, 4) : 40,
                     0, gap, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0, 0);
            if (sel == 0)
            begin
                f.delete();
                repeat ($urandom_range(1, 70))
                    f.push_back(8'($urandom));
                if (f.size() >= 2 && $urandom_range(0, 1))
                begin
                    f[0] = bmpd_pkg::MAGIC_B;
                    f[1] = bmpd_pkg::MAGIC_M;
                end
            end
            else if (sel == 1)
                f[$urandom_range(0, 53)] = 8'($urandom);
            else if (sel == 2)
                while (f.size() > 1 && $urandom_range(0, 7) != 0)
                    void'(f.pop_back());
            send_file(f);
        end
        file_valid <= 1'b0;
        calm = 0;

        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d files, %0d bytes; checked %0d pixels and %0d status words.",
                 files_sent, bytes_sent, sb.pixels_seen, sb.statuses_seen);
        $display("Status counts ok..offset: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
                 sb.status_hits[4], sb.status_hits[5], sb.status_hits[6], sb.status_hits[7],
                 sb.status_hits[8], sb.status_hits[9]);
        if (sb.mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- bmp_stream_decoder_core.f -----
sv/bmpd_pkg.sv
sv/bmpd_ram.sv
sv/bmpd_parse.sv
sv/bmpd_outq.sv
sv/bmp_stream_decoder_core.sv
test/testbench.sv
